FILE: rtl/ows_pkg.sv
`default_nettype none

package ows_pkg;

    localparam int ROM_CODE_W   = 64;
    localparam int FAMILY_LIMIT = 9;
    localparam int FAMILY_W     = 4;
    localparam int FIRST_BYTE_W = 8;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_BEGIN = 2'd1,
        OP_PAIR  = 2'd2
    } t_op;

    typedef struct packed {
        t_op  op;
        logic presence;
        logic id_bit;
        logic complement_bit;
    } t_in_word;

    typedef struct packed {
        logic                    issue_command;
        logic                    write_valid;
        logic                    write_bit;
        logic                    pass_done;
        logic                    found;
        logic [ROM_CODE_W-1:0]   rom_code;
        logic                    last_device;
        logic [FAMILY_W-1:0]     family_discrepancy;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/ows_if.sv
`default_nettype none

interface ows_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;

    modport source (output valid, output op, output presence, output id_bit,
                    output complement_bit, input ready);
    modport sink   (input valid, input op, input presence, input id_bit,
                    input complement_bit, output ready);
endinterface

interface ows_out_if;
    logic                            valid;
    logic                            ready;
    logic                            issue_command;
    logic                            write_valid;
    logic                            write_bit;
    logic                            pass_done;
    logic                            found;
    logic [ows_pkg::ROM_CODE_W-1:0]  rom_code;
    logic                            last_device;
    logic [ows_pkg::FAMILY_W-1:0]    family_discrepancy;

    modport source (output valid, output issue_command, output write_valid,
                    output write_bit, output pass_done, output found,
                    output rom_code, output last_device,
                    output family_discrepancy, input ready);
    modport sink   (input valid, input issue_command, input write_valid,
                    input write_bit, input pass_done, input found,
                    input rom_code, input last_device,
                    input family_discrepancy, output ready);
endinterface

`default_nettype wire

FILE: rtl/ows_core.sv
`default_nettype none

module ows_core #(
    parameter int ROM_BITS = 64
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_fire,
    input  ows_pkg::t_in_word      i_word,
    output ows_pkg::t_result       o_result
);

    localparam int PW = $clog2(ROM_BITS + 2);
    localparam int IW = $clog2(ROM_BITS);

    logic [ROM_BITS-1:0]          r_shadow, n_shadow;
    logic [PW-1:0]                r_last_conflict, n_last_conflict;
    logic [ows_pkg::FAMILY_W-1:0] r_last_family, n_last_family;
    logic                         r_done, n_done;
    logic [PW-1:0]                r_pos, n_pos;
    logic [PW-1:0]                r_last_zero, n_last_zero;
    logic                         r_active, n_active;

    logic [PW-1:0] pos_m1;
    logic [IW-1:0] idx;
    logic          dir;
    ows_pkg::t_result res;

    always_comb begin
        n_shadow        = r_shadow;
        n_last_conflict = r_last_conflict;
        n_last_family   = r_last_family;
        n_done          = r_done;
        n_pos           = r_pos;
        n_last_zero     = r_last_zero;
        n_active        = r_active;
        res             = '0;
        pos_m1          = r_pos - PW'(1);
        idx             = pos_m1[IW-1:0];
        dir             = 1'b0;

        case (i_word.op)
            ows_pkg::OP_CLEAR: begin
                n_shadow        = '0;
                n_last_conflict = '0;
                n_last_family   = '0;
                n_done          = 1'b0;
                n_pos           = PW'(1);
                n_last_zero     = '0;
                n_active        = 1'b0;
            end
            ows_pkg::OP_BEGIN: begin
                n_active    = 1'b0;
                n_pos       = PW'(1);
                n_last_zero = '0;
                if (r_done || !i_word.presence) begin
                    n_last_conflict = '0;
                    n_last_family   = '0;
                    n_done          = 1'b0;
                    res.pass_done   = 1'b1;
                end else begin
                    res.issue_command = 1'b1;
                    n_active          = 1'b1;
                end
            end
            ows_pkg::OP_PAIR: begin
                if (r_active) begin
                    if (i_word.id_bit && i_word.complement_bit) begin
                        // nobody answered this bit: abandon the search
                        n_last_conflict = '0;
                        n_last_family   = '0;
                        n_done          = 1'b0;
                        n_active        = 1'b0;
                        n_pos           = PW'(1);
                        res.pass_done   = 1'b1;
                    end else begin
                        if (i_word.id_bit != i_word.complement_bit) begin
                            dir = i_word.id_bit;
                        end else begin
                            // discrepancy: follow the previous path, then take 1 at the
                            // last conflict, 0 beyond it
                            if (r_pos < r_last_conflict) begin
                                dir = r_shadow[idx];
                            end else begin
                                dir = (r_pos == r_last_conflict);
                            end
                            if (!dir) begin
                                n_last_zero = r_pos;
                                if (r_pos < PW'(ows_pkg::FAMILY_LIMIT)) begin
                                    n_last_family = r_pos[ows_pkg::FAMILY_W-1:0];
                                end
                            end
                        end
                        n_shadow[idx]   = dir;
                        res.write_valid = 1'b1;
                        res.write_bit   = dir;
                        n_pos           = r_pos + PW'(1);
                        if (r_pos == PW'(ROM_BITS)) begin
                            n_active        = 1'b0;
                            n_pos           = PW'(1);
                            res.pass_done   = 1'b1;
                            n_last_conflict = n_last_zero;
                            if (n_last_zero == '0) begin
                                n_done = 1'b1;
                            end
                            if (n_shadow[ows_pkg::FIRST_BYTE_W-1:0] == '0) begin
                                n_last_conflict = '0;
                                n_last_family   = '0;
                                n_done          = 1'b0;
                            end else begin
                                res.found       = 1'b1;
                                res.rom_code    = ows_pkg::ROM_CODE_W'(n_shadow);
                                res.last_device = n_done;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        res.family_discrepancy = n_last_family;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow        <= '0;
            r_last_conflict <= '0;
            r_last_family   <= '0;
            r_done          <= 1'b0;
            r_pos           <= PW'(1);
            r_last_zero     <= '0;
            r_active        <= 1'b0;
        end else if (i_fire) begin
            r_shadow        <= n_shadow;
            r_last_conflict <= n_last_conflict;
            r_last_family   <= n_last_family;
            r_done          <= n_done;
            r_pos           <= n_pos;
            r_last_zero     <= n_last_zero;
            r_active        <= n_active;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/onewire_rom_search_engine.sv
// a result is registered in the output register, or in the skid stage on a stall
// one word per cycle unless the skid stage is full; state updates on acceptance
// an output register plus one skid stage keep ready high while a result waits
// reset: synchronous, active low; clears the search state (bit position back to 1)
// and empties the output stages
`default_nettype none

module onewire_rom_search_engine #(
    parameter int ROM_BITS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ows_in_if.sink      i_in,
    ows_out_if.source   o_out
);

    ows_pkg::t_in_word in_word;
    ows_pkg::t_result  res;
    logic              in_fire;
    logic              out_fire;

    ows_pkg::t_result  r_out, n_out;
    ows_pkg::t_result  r_skd, n_skd;
    logic              r_out_valid, n_out_valid;
    logic              r_skd_valid, n_skd_valid;

    assign in_word.op             = ows_pkg::t_op'(i_in.op);
    assign in_word.presence       = i_in.presence;
    assign in_word.id_bit         = i_in.id_bit;
    assign in_word.complement_bit = i_in.complement_bit;

    assign i_in.ready = !r_skd_valid;
    assign in_fire    = i_in.valid && !r_skd_valid;
    assign out_fire   = r_out_valid && o_out.ready;

    ows_core #(
        .ROM_BITS (ROM_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_fire),
        .i_word   (in_word),
        .o_result (res)
    );

    always_comb begin
        n_out       = r_out;
        n_skd       = r_skd;
        n_out_valid = r_out_valid;
        n_skd_valid = r_skd_valid;
        if (r_skd_valid) begin
            if (out_fire) begin
                n_out       = r_skd;
                n_skd_valid = 1'b0;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                // output stalled: park the new word
                n_skd       = res;
                n_skd_valid = 1'b1;
            end
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_skd_valid <= n_skd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_skd <= n_skd;
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.issue_command      = r_out.issue_command;
    assign o_out.write_valid        = r_out.write_valid;
    assign o_out.write_bit          = r_out.write_bit;
    assign o_out.pass_done          = r_out.pass_done;
    assign o_out.found              = r_out.found;
    assign o_out.rom_code           = r_out.rom_code;
    assign o_out.last_device        = r_out.last_device;
    assign o_out.family_discrepancy = r_out.family_discrepancy;

endmodule

`default_nettype wire

FILE: rtl/ows_checker.sv
`default_nettype none

module ows_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_out_valid,
    input wire                           i_out_ready,
    input wire                           i_issue_command,
    input wire                           i_write_valid,
    input wire                           i_write_bit,
    input wire                           i_pass_done,
    input wire                           i_found,
    input wire [ows_pkg::ROM_CODE_W-1:0] i_rom_code,
    input wire                           i_last_device
);

    // a found device always closes the pass with a nonzero family byte
    a_found_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found |-> i_pass_done && (i_rom_code[7:0] != 8'd0))
        else $error("found word without pass end or with zero family byte");

    a_bit_needs_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_write_bit |-> i_write_valid)
        else $error("direction bit set without a write");

    a_last_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last_device |-> i_found)
        else $error("last device flagged without a found code");

    a_command_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_issue_command |-> !i_pass_done && !i_write_valid)
        else $error("command issue mixed with bit or pass end");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rom_code))
        else $error("stalled output word dropped or changed");

endmodule

bind onewire_rom_search_engine ows_checker u_ows_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_issue_command (o_out.issue_command),
    .i_write_valid   (o_out.write_valid),
    .i_write_bit     (o_out.write_bit),
    .i_pass_done     (o_out.pass_done),
    .i_found         (o_out.found),
    .i_rom_code      (o_out.rom_code),
    .i_last_device   (o_out.last_device)
);

`default_nettype wire
